>>> rtl/core/lphi_pkg.sv
// Package for the linear-probe hash insert block: table geometry, field widths,
// mode and register codes. No dependencies.
package lphi_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int SIZE_W      = SLOT_W + 1;
    localparam int KEY_W       = 31;
    localparam int KEY_OUT_W   = 32;
    localparam int YEAR_W      = 16;
    localparam int SCORE_W     = 10;
    localparam int PAYLOAD_W   = YEAR_W + 1 + SCORE_W;
    localparam int COUNT_W     = 32;
    localparam int LOAD_W      = COUNT_W + 4;
    localparam int DIV_DIGIT   = 4;
    localparam int DIV_STEPS   = (KEY_W + DIV_DIGIT) / DIV_DIGIT;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(TABLE_DEPTH);

    // Request modes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    // Register word indexes
    localparam logic REG_TABLE_SIZE = 1'b0;

endpackage

>>> rtl/core/linear_probe_hash_insert.sv
// Linear-probe hash insert: key and payload stores in two lphi_ram instances; needs lphi_pkg.
// An insert runs a load check, then the remainder digits of the key modulo the size, then
// a RAM read and a check per probe; a read, or an insert refused on load, ends after one step.
// One request at a time: busy drops in the strobe cycle, and a new request can be taken then.
// Sync active-low reset, then a clear of every key entry in the key store with busy high.
// Results are strobed for one cycle; the receiver cannot stall.
module linear_probe_hash_insert (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_mode,
    input  logic [lphi_pkg::KEY_W-1:0]      i_record_key,
    input  logic [lphi_pkg::YEAR_W-1:0]     i_birth_year,
    input  logic                            i_gender_flag,
    input  logic [lphi_pkg::SCORE_W-1:0]    i_average_score,
    input  logic [lphi_pkg::SLOT_W-1:0]     i_slot_select,
    output logic                            o_done,
    output logic                            o_accepted,
    output logic [lphi_pkg::SLOT_W-1:0]     o_slot_used,
    output logic                            o_occupied,
    output logic signed [lphi_pkg::KEY_OUT_W-1:0] o_key_out,
    output logic [lphi_pkg::YEAR_W-1:0]     o_year_out,
    output logic                            o_gender_out,
    output logic [lphi_pkg::SCORE_W-1:0]    o_score_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lphi_pkg::PADDR_W-1:0]    paddr,
    input  logic [lphi_pkg::PDATA_W-1:0]    pwdata,
    output logic [lphi_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);
    import lphi_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_READ_OUT
    } t_state;

    // Sequencer state
    t_state                 r_state,     n_state;
    logic [SLOT_W-1:0]      r_clr_addr,  n_clr_addr;
    logic [COUNT_W-1:0]     r_count,     n_count;
    logic [SIZE_W-1:0]      r_table_size;
    logic [SIZE_W-1:0]      r_size,      n_size;
    logic [KEY_W-1:0]       r_key,       n_key;
    logic [PAYLOAD_W-1:0]   r_payload,   n_payload;
    logic [KEY_W:0]         r_div_sh,    n_div_sh;
    logic [DIV_CNT_W-1:0]   r_div_cnt,   n_div_cnt;
    logic [SIZE_W-1:0]      r_rem,       n_rem;
    logic [SLOT_W-1:0]      r_idx,       n_idx;
    logic [SIZE_W-1:0]      r_probes,    n_probes;

    // Registered result
    logic                   r_done,      n_done;
    logic                   r_accepted,  n_accepted;
    logic [SLOT_W-1:0]      r_slot,      n_slot;
    logic                   r_occupied,  n_occupied;
    logic [KEY_W-1:0]       r_key_out,   n_key_out;
    logic [PAYLOAD_W-1:0]   r_pay_out,   n_pay_out;

    // RAM ports
    logic                   key_we, pay_we;
    logic [SLOT_W-1:0]      ram_waddr, ram_raddr;
    logic [KEY_W-1:0]       key_wdata, key_rdata;
    logic [PAYLOAD_W-1:0]   pay_rdata;

    // Datapath helpers
    logic                   accept;
    logic                   cfg_write;
    logic [SIZE_W-1:0]      size_eff;
    logic [LOAD_W-1:0]      load_lhs, load_rhs;
    logic [SIZE_W-1:0]      rem_step;
    logic [SIZE_W-1:0]      idx_inc;

    assign accept    = start && (r_state == S_IDLE);
    assign busy      = (r_state != S_IDLE);
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_TABLE_SIZE);
    assign prdata    = (paddr[2] == REG_TABLE_SIZE) ? PDATA_W'(r_table_size) : '0;

    // Clamp the configured size into 1..TABLE_DEPTH
    always_comb begin
        size_eff = r_table_size;
        if (r_table_size == '0) begin
            size_eff = SIZE_W'(1);
        end else if (r_table_size > SIZE_W'(TABLE_DEPTH)) begin
            size_eff = SIZE_W'(TABLE_DEPTH);
        end
    end

    // Load test: count*10 >= size*7
    assign load_lhs = (LOAD_W'(r_count) << 3) + (LOAD_W'(r_count) << 1);
    assign load_rhs = (LOAD_W'(r_size) << 3) - LOAD_W'(r_size);

    // One radix-16 remainder digit per cycle, four compare-subtract steps
    always_comb begin
        rem_step = r_rem;
        for (int b = 0; b < DIV_DIGIT; b++) begin
            rem_step = {rem_step[SIZE_W-2:0], r_div_sh[KEY_W - b]};
            if (rem_step >= r_size) begin
                rem_step = rem_step - r_size;
            end
        end
    end

    assign idx_inc = SIZE_W'(r_idx) + SIZE_W'(1);

    // RAM address and write control
    always_comb begin
        ram_raddr = (r_state == S_IDLE) ? i_slot_select : r_idx;
        ram_waddr = r_idx;
        key_wdata = r_key;
        key_we    = 1'b0;
        pay_we    = 1'b0;
        if (r_state == S_CLEAR) begin
            ram_waddr = r_clr_addr;
            key_wdata = '0;
            key_we    = 1'b1;
        end else if (r_state == S_PROBE_CHK && key_rdata == '0) begin
            key_we = 1'b1;
            pay_we = 1'b1;
        end
    end

    lphi_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (ram_waddr),
        .i_wdata (key_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (key_rdata)
    );

    lphi_ram #(.WIDTH(PAYLOAD_W), .DEPTH(TABLE_DEPTH)) u_pay_ram (
        .i_clk   (i_clk),
        .i_we    (pay_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_payload),
        .i_raddr (ram_raddr),
        .o_rdata (pay_rdata)
    );

    // Next-state logic
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_count    = r_count;
        n_size     = r_size;
        n_key      = r_key;
        n_payload  = r_payload;
        n_div_sh   = r_div_sh;
        n_div_cnt  = r_div_cnt;
        n_rem      = r_rem;
        n_idx      = r_idx;
        n_probes   = r_probes;
        n_done     = 1'b0;
        n_accepted = 1'b0;
        n_slot     = '0;
        n_occupied = 1'b0;
        n_key_out  = '0;
        n_pay_out  = '0;

        case (r_state)
            S_CLEAR: begin
                // sweep every key entry to empty
                n_clr_addr = r_clr_addr + SLOT_W'(1);
                if (r_clr_addr == SLOT_W'(TABLE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_key     = i_record_key;
                    n_payload = {i_birth_year, i_gender_flag, i_average_score};
                    n_idx     = i_slot_select;
                    n_size    = size_eff;
                    if (i_mode == MODE_READ) begin
                        n_state = S_READ_OUT;
                    end else begin
                        // every insert counts, saturating
                        if (r_count != '1) begin
                            n_count = r_count + COUNT_W'(1);
                        end
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (load_lhs >= load_rhs) begin
                    // refuse on load: empty result
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_div_sh  = {1'b0, r_key};
                    n_div_cnt = '0;
                    n_rem     = '0;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                n_rem     = rem_step;
                n_div_sh  = r_div_sh << DIV_DIGIT;
                n_div_cnt = r_div_cnt + DIV_CNT_W'(1);
                if (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_idx    = rem_step[SLOT_W-1:0];
                    n_probes = '0;
                    n_state  = S_PROBE_RD;
                end
            end
            S_PROBE_RD: begin
                n_state = S_PROBE_CHK;
            end
            S_PROBE_CHK: begin
                if (key_rdata == '0) begin
                    // free slot: RAM write happens this cycle
                    n_done     = 1'b1;
                    n_accepted = 1'b1;
                    n_slot     = r_idx;
                    n_state    = S_IDLE;
                end else if (r_probes == r_size - SIZE_W'(1)) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_idx    = (idx_inc == r_size) ? '0 : idx_inc[SLOT_W-1:0];
                    n_probes = r_probes + SIZE_W'(1);
                    n_state  = S_PROBE_RD;
                end
            end
            S_READ_OUT: begin
                n_done     = 1'b1;
                n_slot     = r_idx;
                n_key_out  = key_rdata;
                n_occupied = (key_rdata != '0);
                n_pay_out  = (key_rdata != '0) ? pay_rdata : '0;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_count      <= '0;
            r_table_size <= SIZE_RESET;
            r_done       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_count    <= n_count;
            r_done     <= n_done;
            if (cfg_write) begin
                r_table_size <= pwdata[SIZE_W-1:0];
            end
        end
        r_size     <= n_size;
        r_key      <= n_key;
        r_payload  <= n_payload;
        r_div_sh   <= n_div_sh;
        r_div_cnt  <= n_div_cnt;
        r_rem      <= n_rem;
        r_idx      <= n_idx;
        r_probes   <= n_probes;
        r_accepted <= n_accepted;
        r_slot     <= n_slot;
        r_occupied <= n_occupied;
        r_key_out  <= n_key_out;
        r_pay_out  <= n_pay_out;
    end

    assign o_done       = r_done;
    assign o_accepted   = r_accepted;
    assign o_slot_used  = r_slot;
    assign o_occupied   = r_occupied;
    assign o_key_out    = {1'b0, r_key_out};
    assign o_year_out   = r_pay_out[PAYLOAD_W-1 -: YEAR_W];
    assign o_gender_out = r_pay_out[SCORE_W];
    assign o_score_out  = r_pay_out[SCORE_W-1:0];

    // A result always lands with the sequencer back in idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_state == S_IDLE))
        else $error("result strobed while sequencer busy");

    // Accepted request makes the block busy next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not start work");

    // Insert results never report read-slot fields
    a_insert_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_accepted) |-> (!o_occupied && o_key_out == '0))
        else $error("insert result carries read fields");

    // Probe counter stays below the table size
    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE_CHK) |-> (r_probes < r_size))
        else $error("probe walk ran past table size");

endmodule

>>> rtl/core/lphi_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module lphi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> dv/tb_linear_probe_hash_insert.sv
// Self-checking testbench for linear_probe_hash_insert: APB table-size setup,
// directed and random insert/read requests, and a scoreboard that predicts each result.
// Depends on lphi_pkg and the RTL of the block (with its lphi_ram instances).
module tb_linear_probe_hash_insert;
    timeunit 1ns;
    timeprecision 1ps;

    import lphi_pkg::*;

    // Cycle budget: the slowest legal insert walks the whole table,
    // plus sender gaps, the clearing pass and config traffic.
    localparam int unsigned RUN_LIMIT   = 8_000_000;
    localparam int unsigned PRINT_LIMIT = 200;

    typedef struct {
        logic                 mode;
        logic [KEY_W-1:0]     key;
        logic [YEAR_W-1:0]    year;
        logic                 gender;
        logic [SCORE_W-1:0]   score;
        logic [SLOT_W-1:0]    sel;
    } slot_request_t;

    typedef struct {
        logic                 accepted;
        logic [SLOT_W-1:0]    slot;
        logic                 occupied;
        logic [KEY_OUT_W-1:0] key;
        logic [YEAR_W-1:0]    year;
        logic                 gender;
        logic [SCORE_W-1:0]   score;
    } slot_outcome_t;

    // Scoreboard: mirrors the key and payload stores, the attempt counter and the
    // table size, predicts the outcome of every accepted request and checks results
    // against the oldest outstanding prediction.
    class slot_table_scoreboard;
        bit [KEY_W-1:0]    slot_key     [TABLE_DEPTH];
        bit [YEAR_W-1:0]   slot_year    [TABLE_DEPTH];
        bit                slot_gender  [TABLE_DEPTH];
        bit [SCORE_W-1:0]  slot_score   [TABLE_DEPTH];
        bit                slot_written [TABLE_DEPTH];
        int unsigned       written_slots[$];
        bit [COUNT_W-1:0]  attempts;
        bit [SIZE_W-1:0]   size_reg;
        slot_outcome_t     pending_outcomes[$];
        int unsigned       mismatch_count;

        function new();
            attempts       = '0;
            size_reg       = SIZE_RESET;
            mismatch_count = 0;
        endfunction

        function void set_size(input bit [SIZE_W-1:0] value);
            size_reg = value;
        endfunction

        // Zero acts as one slot, anything past the depth as the full depth.
        function int unsigned live_size();
            if (size_reg == 0) return 1;
            if (size_reg > TABLE_DEPTH) return TABLE_DEPTH;
            return size_reg;
        endfunction

        function int unsigned outstanding();
            return pending_outcomes.size();
        endfunction

        // Random reads only pick slots whose payload was stored.
        function int unsigned pick_written_slot();
            return written_slots[$urandom_range(0, written_slots.size() - 1)];
        endfunction

        function slot_outcome_t predict_slot_outcome(input slot_request_t r);
            slot_outcome_t o;
            int unsigned   span;
            int unsigned   first;
            int unsigned   idx;
            int unsigned   probe;
            bit            found;
            o     = '{default: 0};
            found = 1'b0;
            idx   = 0;
            if (r.mode == MODE_INSERT) begin
                span = live_size();
                // Count every attempt, refused or not; saturate at all ones.
                if (attempts != '1) attempts++;
                if (64'(attempts) * 10 >= 64'(span) * 7) return o;
                first = r.key % span;
                // Walk from the home slot, wrapping inside the live size. Stored keys
                // are 31 bits, so a free slot is simply key zero.
                for (probe = 0; probe < span && !found; probe++) begin
                    idx = first + probe;
                    if (idx >= span) idx -= span;
                    found = (slot_key[idx] == '0);
                end
                if (!found) return o;
                slot_key[idx]    = r.key;
                slot_year[idx]   = r.year;
                slot_gender[idx] = r.gender;
                slot_score[idx]  = r.score;
                if (!slot_written[idx]) written_slots.push_back(idx);
                slot_written[idx] = 1'b1;
                o.accepted = 1'b1;
                o.slot     = SLOT_W'(idx);
            end else begin
                idx        = r.sel;
                o.slot     = r.sel;
                o.key      = {1'b0, slot_key[idx]};
                o.occupied = (slot_key[idx] != '0);
                if (o.occupied) begin
                    o.year   = slot_year[idx];
                    o.gender = slot_gender[idx];
                    o.score  = slot_score[idx];
                end
            end
            return o;
        endfunction

        function void note_request(input slot_request_t r);
            pending_outcomes.push_back(predict_slot_outcome(r));
        endfunction

        task report_mismatch(input string msg);
            if (mismatch_count < PRINT_LIMIT)
                $display("%0t ns  mismatch: %s", $time, msg);
            mismatch_count++;
        endtask

        task check_result(input slot_outcome_t got);
            slot_outcome_t want;
            logic [63:0]   got_v  [7];
            logic [63:0]   want_v [7];
            string         names  [7];
            string         bad;
            if (pending_outcomes.size() == 0) begin
                report_mismatch($sformatf("result with no request pending (slot %0d)",
                                          got.slot));
                return;
            end
            want   = pending_outcomes.pop_front();
            names  = '{"accepted", "slot_used", "occupied", "key_out", "year_out",
                       "gender_out", "score_out"};
            got_v  = '{64'(got.accepted), 64'(got.slot), 64'(got.occupied), 64'(got.key),
                       64'(got.year), 64'(got.gender), 64'(got.score)};
            want_v = '{64'(want.accepted), 64'(want.slot), 64'(want.occupied),
                       64'(want.key), 64'(want.year), 64'(want.gender), 64'(want.score)};
            bad = "";
            foreach (names[i])
                if (got_v[i] !== want_v[i])
                    bad = {bad, $sformatf(" %s=%0h(exp %0h)", names[i], got_v[i], want_v[i])};
            if (bad != "") report_mismatch(bad);
        endtask
    endclass

    // Clock, reset and every block input start at known values.
    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  start           = 1'b0;
    logic                  i_mode          = MODE_INSERT;
    logic [KEY_W-1:0]      i_record_key    = '0;
    logic [YEAR_W-1:0]     i_birth_year    = '0;
    logic                  i_gender_flag   = 1'b0;
    logic [SCORE_W-1:0]    i_average_score = '0;
    logic [SLOT_W-1:0]     i_slot_select   = '0;
    logic                  psel            = 1'b0;
    logic                  penable         = 1'b0;
    logic                  pwrite          = 1'b0;
    logic [PADDR_W-1:0]    paddr           = '0;
    logic [PDATA_W-1:0]    pwdata          = '0;

    logic                  busy;
    logic                  o_done;
    logic                  o_accepted;
    logic [SLOT_W-1:0]     o_slot_used;
    logic                  o_occupied;
    logic signed [KEY_OUT_W-1:0] o_key_out;
    logic [YEAR_W-1:0]     o_year_out;
    logic                  o_gender_out;
    logic [SCORE_W-1:0]    o_score_out;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    slot_table_scoreboard  sb;
    int unsigned           cycle_count = 0;
    int unsigned           burst_left  = 0;

    linear_probe_hash_insert dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_record_key    (i_record_key),
        .i_birth_year    (i_birth_year),
        .i_gender_flag   (i_gender_flag),
        .i_average_score (i_average_score),
        .i_slot_select   (i_slot_select),
        .o_done          (o_done),
        .o_accepted      (o_accepted),
        .o_slot_used     (o_slot_used),
        .o_occupied      (o_occupied),
        .o_key_out       (o_key_out),
        .o_year_out      (o_year_out),
        .o_gender_out    (o_gender_out),
        .o_score_out     (o_score_out),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #1 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Monitor: sample at the clock edge, so everything seen here is the value
    // that held during the cycle just ended. Check the result before noting a
    // new request; a result always belongs to an earlier request.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.check_result('{o_accepted, o_slot_used, o_occupied, o_key_out,
                              o_year_out, o_gender_out, o_score_out});
        if (i_rst_n && start && !busy)
            sb.note_request('{i_mode, i_record_key, i_birth_year, i_gender_flag,
                              i_average_score, i_slot_select});
    end

    function automatic slot_request_t make_req(input logic mode, input int unsigned key,
                                               input int unsigned year, input logic gender,
                                               input int unsigned score,
                                               input int unsigned sel);
        return '{mode, KEY_W'(key), YEAR_W'(year), gender, SCORE_W'(score), SLOT_W'(sel)};
    endfunction

    // Random request: half inserts, half reads of slots that hold a stored payload.
    // Keys are mostly wide random values, with a share of small keys and of keys
    // that all hash near the bottom of the table to build long probe clusters.
    function automatic slot_request_t random_request();
        slot_request_t r;
        int unsigned   pick;
        r.mode   = ($urandom_range(0, 99) < 50) ? MODE_READ : MODE_INSERT;
        r.key    = KEY_W'($urandom);
        r.year   = YEAR_W'($urandom);
        r.gender = 1'($urandom);
        r.score  = SCORE_W'($urandom_range(0, 1000));
        r.sel    = SLOT_W'($urandom);
        pick     = $urandom_range(0, 9);
        if (pick < 2)
            r.key = KEY_W'($urandom_range(0, 2047));
        else if (pick < 4)
            r.key = KEY_W'($urandom_range(0, 31) + sb.live_size() * $urandom_range(0, 1000));
        if (r.mode == MODE_READ)
            r.sel = SLOT_W'(sb.pick_written_slot());
        return r;
    endfunction

    // Drive one request and hold it until accepted. Start stays high across
    // back-to-back requests; a gap lowers it between bursts.
    task automatic send_request(input slot_request_t r);
        int unsigned gap;
        start           <= 1'b1;
        i_mode          <= r.mode;
        i_record_key    <= r.key;
        i_birth_year    <= r.year;
        i_gender_flag   <= r.gender;
        i_average_score <= r.score;
        i_slot_select   <= r.sel;
        do @(posedge i_clk); while (busy);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 10);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Drop start and wait until the block is idle with nothing outstanding.
    task automatic settle();
        start <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (sb.outstanding() != 0 || busy) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // One APB transfer followed by an idle cycle on the bus.
    task automatic apb_access(input logic write, input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= PADDR_W'({REG_TABLE_SIZE, 2'b00});
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write the table size, mirror it in the scoreboard and read it back.
    task automatic program_table_size(input int unsigned value);
        logic [PDATA_W-1:0] rdata;
        apb_access(1'b1, PDATA_W'(value), rdata);
        sb.set_size(SIZE_W'(value));
        apb_access(1'b0, '0, rdata);
        if (rdata !== PDATA_W'(SIZE_W'(value)))
            sb.report_mismatch($sformatf("table_size reads %0h, wrote %0h", rdata, value));
    endtask

    initial begin
        logic [PDATA_W-1:0] rdata;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Hold off until the clearing pass over the key store has finished.
        settle();
        apb_access(1'b0, '0, rdata);
        if (rdata !== PDATA_W'(SIZE_RESET))
            sb.report_mismatch($sformatf("table_size after reset reads %0h", rdata));

        // Two-slot table: first insert fits, the second trips the load limit.
        program_table_size(2);
        send_request(make_req(MODE_INSERT, 3, 0, 1'b0, 0, 0));
        send_request(make_req(MODE_READ, 32'h7FFF_FFFF, 65535, 1'b1, 1000, 1));
        send_request(make_req(MODE_INSERT, 5, 65535, 1'b1, 1000, 1023));
        settle();

        // Size zero behaves as one slot: always refused by load.
        program_table_size(0);
        send_request(make_req(MODE_INSERT, 7, 1, 1'b0, 1, 0));
        settle();

        // Oversized value clamps to the full depth. Exercise the widest key and
        // payload, wraparound past the last slot, the zero key that leaves its
        // slot free, and a probe walk through a run of taken slots.
        program_table_size(2047);
        send_request(make_req(MODE_INSERT, 32'h7FFF_FFFF, 65535, 1'b1, 1000, 0));
        send_request(make_req(MODE_INSERT, 1023, 1, 1'b0, 1, 0));
        send_request(make_req(MODE_INSERT, 0, 2000, 1'b1, 500, 0));
        send_request(make_req(MODE_READ, 0, 0, 1'b0, 0, 2));
        send_request(make_req(MODE_INSERT, 2, 1999, 1'b0, 999, 0));
        send_request(make_req(MODE_READ, 0, 0, 1'b0, 0, 2));
        send_request(make_req(MODE_INSERT, 1, 42, 1'b1, 7, 0));
        send_request(make_req(MODE_INSERT, 1025, 32768, 1'b0, 512, 0));
        send_request(make_req(MODE_READ, 0, 0, 1'b0, 0, 1023));
        send_request(make_req(MODE_READ, 0, 0, 1'b0, 0, 0));
        send_request(make_req(MODE_READ, 0, 0, 1'b0, 0, 3));
        send_request(make_req(MODE_READ, 0, 0, 1'b0, 0, 4));
        send_request(make_req(MODE_READ, 0, 0, 1'b0, 0, 1));
        settle();

        program_table_size(TABLE_DEPTH);
        send_request(make_req(MODE_INSERT, 2047, 12345, 1'b1, 250, 0));
        send_request(make_req(MODE_READ, 0, 0, 1'b0, 0, 5));
        settle();

        // Shrink while in use: inserts refused, slots past the size still readable.
        program_table_size(3);
        send_request(make_req(MODE_INSERT, 9, 9, 1'b1, 9, 0));
        send_request(make_req(MODE_READ, 0, 0, 1'b0, 0, 1023));
        settle();

        // Random traffic at full depth, then a mid size, then small sizes where
        // the attempt count keeps every insert refused.
        program_table_size(TABLE_DEPTH);
        repeat (320) send_request(random_request());
        settle();
        program_table_size($urandom_range(600, 1023));
        repeat (250) send_request(random_request());
        settle();
        program_table_size($urandom_range(1, 40));
        repeat (150) send_request(random_request());
        settle();
        program_table_size(1);
        repeat (10) send_request(random_request());
        settle();
        repeat (16) @(posedge i_clk);

        if (sb.mismatch_count == 0 && sb.outstanding() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
